// ===== rtl/core/mips_subset_core_step_top_defines.svh =====
// Assertion helpers, clocked on clk and held off during rst.
`ifndef MIPS_SUBSET_CORE_STEP_TOP_DEFINES_SVH
`define MIPS_SUBSET_CORE_STEP_TOP_DEFINES_SVH

// Same-cycle implication.
`define MSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/msc_pkg.sv =====
package msc_pkg;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_JUMP  = 6'd2;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_LOAD  = 6'd35;
  localparam logic [5:0] OP_STORE = 6'd43;
  localparam logic [5:0] OP_HALT  = 6'd63;

  localparam logic [2:0] FN_ADDU = 3'd1;
  localparam logic [2:0] FN_SUBU = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_NOR  = 3'd7;

  localparam logic [31:0] PC_RESET = 32'd4;

  // write-back stage contents
  typedef struct packed {
    logic        we;
    logic        load;
    logic [4:0]  idx;
    logic [1:0]  off;
    logic [31:0] alu;
  } wb_t;

  function automatic logic [5:0] f_op(input logic [31:0] w);
    return w[31:26];
  endfunction

  function automatic logic [4:0] f_rs(input logic [31:0] w);
    return w[25:21];
  endfunction

  function automatic logic [4:0] f_rt(input logic [31:0] w);
    return w[20:16];
  endfunction

  function automatic logic [4:0] f_rd(input logic [31:0] w);
    return w[15:11];
  endfunction

  function automatic logic [31:0] sext16(input logic [31:0] w);
    return {{16{w[15]}}, w[15:0]};
  endfunction

endpackage

// ===== rtl/core/mips_subset_core_step_top.sv =====
// Channel  Handshake                    Payload
// request  instr_valid / instr_ready    instruction
// result   result_valid / result_ready  fetch_address, reg_write_*, store_*, halted
//
// One request per cycle unless the output is held; execute feeds the output register.
// Rate is set by the single port of each data memory byte bank and the one register file
// write port; loads write back one stage later, forwarded into execute.
// Reset clears data memory one 4-byte row per cycle, taking no request until done.
// A held result freezes execute, write-back. DMEM_BYTES must be a power of two, unchecked.
`include "mips_subset_core_step_top_defines.svh"

module mips_subset_core_step_top
  import msc_pkg::*;
#(
  parameter int DMEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        instr_valid,
  output logic        instr_ready,
  input  logic [31:0] instruction,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] fetch_address,
  output logic        reg_write_valid,
  output logic [4:0]  reg_write_index,
  output logic [31:0] reg_write_value,
  output logic        store_valid,
  output logic [31:0] store_address,
  output logic [31:0] store_value,
  output logic        halted
);

  localparam int AW   = $clog2(DMEM_BYTES);
  localparam int ROWS = DMEM_BYTES / 4;
  localparam int RW   = AW - 2;

  logic          clearing;
  logic [RW-1:0] clr_row;
  logic          adv;
  logic          accept;

  logic          e_valid;
  logic [31:0]   e_inst;
  logic [31:0]   rf_a;
  logic [31:0]   rf_b;

  logic          m_valid;
  wb_t           m_wb;
  logic [31:0]   ld_word;
  logic [31:0]   m_wdata;
  logic          m_wr;

  logic [31:0]   rf [32];
  logic [31:0]   rf_vld;

  logic          stopped;
  logic [31:0]   pc;
  logic [31:0]   last_alu;
  logic          rep_valid;
  logic [31:0]   rep_addr;
  logic [31:0]   rep_val;

  logic [7:0]    dmem [4][ROWS];
  logic [7:0]    rd_byte [4];
  logic [RW-1:0] bank_row [4];
  logic [7:0]    bank_wd [4];
  logic          bank_we;
  logic          mem_re;

  logic [5:0]    e_op;
  logic          exec;
  logic          is_r;
  logic          is_addiu;
  logic          is_load;
  logic          is_store;
  logic          is_jump;
  logic          is_halt;
  logic [31:0]   op_a;
  logic [31:0]   op_b;
  logic [31:0]   sum_i;
  logic [31:0]   alu_r;
  logic [31:0]   e_res;
  logic          e_we;
  logic [4:0]    e_idx;
  logic [31:0]   e_fetch;
  logic [AW-1:0] maddr;

  assign adv         = !result_valid || result_ready;
  assign instr_ready = !clearing && (!e_valid || adv);
  assign accept      = instr_valid && instr_ready;

  // write-back: load word assembled big-endian from the byte banks
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_word[31 - 8 * i -: 8] = rd_byte[m_wb.off + 2'(i)];
    end
  end

  assign m_wdata = m_wb.load ? ld_word : m_wb.alu;
  assign m_wr    = m_valid && m_wb.we && adv;

  // execute
  assign e_op     = f_op(e_inst);
  assign exec     = e_valid && !stopped;
  assign is_r     = e_op == OP_RTYPE;
  assign is_addiu = e_op == OP_ADDIU;
  assign is_load  = e_op == OP_LOAD;
  assign is_store = e_op == OP_STORE;
  assign is_jump  = e_op == OP_JUMP;
  assign is_halt  = e_op == OP_HALT;

  assign op_a = (m_valid && m_wb.we && m_wb.idx == f_rs(e_inst)) ? m_wdata : rf_a;
  assign op_b = (m_valid && m_wb.we && m_wb.idx == f_rt(e_inst)) ? m_wdata : rf_b;

  assign sum_i = op_a + sext16(e_inst);

  always_comb begin
    case (e_inst[2:0])
      FN_ADDU: alu_r = op_a + op_b;
      FN_SUBU: alu_r = op_a - op_b;
      FN_AND:  alu_r = op_a & op_b;
      FN_OR:   alu_r = op_a | op_b;
      FN_NOR:  alu_r = ~(op_a | op_b);
      default: alu_r = last_alu;
    endcase
  end

  assign e_res   = is_r ? alu_r : sum_i;
  assign e_we    = is_r || is_addiu;
  assign e_idx   = is_r ? f_rd(e_inst) : f_rt(e_inst);
  assign e_fetch = is_jump ? {6'd0, e_inst[25:0]} : pc;

  // data memory: four byte banks, byte address modulo DMEM_BYTES
  assign maddr   = sum_i[AW-1:0];
  assign bank_we = clearing || (adv && exec && is_store);
  assign mem_re  = adv && exec && is_load;

  always_comb begin
    logic [1:0] lane;
    for (int b = 0; b < 4; b++) begin
      lane        = 2'(b) - maddr[1:0];
      bank_row[b] = clearing ? clr_row : maddr[AW-1:2] + RW'(2'(b) < maddr[1:0]);
      bank_wd[b]  = clearing ? 8'd0 : op_b[{2'd3 - lane, 3'b000} +: 8];
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    always_ff @(posedge clk) begin
      if (bank_we) begin
        dmem[b][bank_row[b]] <= bank_wd[b];
      end
      if (mem_re) begin
        rd_byte[b] <= dmem[b][bank_row[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + RW'(1);
      if (clr_row == RW'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // register file: two reads at acceptance, write-through from write-back
  always_ff @(posedge clk) begin
    if (m_wr) begin
      rf[m_wb.idx] <= m_wdata;
    end
    if (accept) begin
      e_inst <= instruction;
      if (m_wr && m_wb.idx == f_rs(instruction)) begin
        rf_a <= m_wdata;
      end else begin
        rf_a <= rf_vld[f_rs(instruction)] ? rf[f_rs(instruction)] : 32'd0;
      end
      if (m_wr && m_wb.idx == f_rt(instruction)) begin
        rf_b <= m_wdata;
      end else begin
        rf_b <= rf_vld[f_rt(instruction)] ? rf[f_rt(instruction)] : 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (m_wr) begin
      rf_vld[m_wb.idx] <= 1'b1;
    end
  end

  // pipeline control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid   <= 1'b0;
      m_valid   <= 1'b0;
      stopped   <= 1'b0;
      pc        <= PC_RESET;
      last_alu  <= '0;
      rep_valid <= 1'b0;
    end else begin
      if (accept) begin
        e_valid <= 1'b1;
      end else if (adv) begin
        e_valid <= 1'b0;
      end
      if (adv) begin
        m_valid <= exec && (e_we || is_load);
      end
      if (adv && exec) begin
        rep_valid <= is_store;
        if (is_halt) begin
          stopped <= 1'b1;
        end else begin
          pc <= e_fetch + 32'd4;
        end
        if (e_we) begin
          last_alu <= e_res;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_wb.we   <= e_we || is_load;
      m_wb.load <= is_load;
      m_wb.idx  <= e_idx;
      m_wb.off  <= maddr[1:0];
      m_wb.alu  <= e_res;
    end
    if (adv && exec) begin
      rep_addr <= sum_i;
      rep_val  <= op_b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e_valid) begin
      halted          <= stopped || is_halt;
      fetch_address   <= (stopped || is_halt) ? 32'd0 : e_fetch;
      reg_write_valid <= exec && e_we;
      reg_write_index <= (exec && e_we) ? e_idx : 5'd0;
      reg_write_value <= (exec && e_we) ? e_res : 32'd0;
      store_valid     <= !stopped && rep_valid;
      store_address   <= (!stopped && rep_valid) ? rep_addr : 32'd0;
      store_value     <= (!stopped && rep_valid) ? rep_val : 32'd0;
    end
  end

  `MSC_ASSERT_NEXT(a_stop_sticks, stopped, stopped, "halt state was left")
  `MSC_ASSERT_NOW(a_clear_idle, clearing, !e_valid && !m_valid, "pipeline busy during clear")
  `MSC_ASSERT_NOW(a_no_run_after_halt, result_valid && !halted, !stopped,
                  "non-halted result after halt")
  `MSC_ASSERT_NEXT(a_halt_result, adv && exec && is_halt, stopped && result_valid && halted,
                   "halt did not reach the output")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import msc_pkg::*;

  localparam int DMEM_SIZE = 65536;
  localparam int TOTAL_ITEMS = 1050;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] fetch_address;
    logic        reg_write_valid;
    logic [4:0]  reg_write_index;
    logic [31:0] reg_write_value;
    logic        store_valid;
    logic [31:0] store_address;
    logic [31:0] store_value;
    logic        halted;
  } result_t;

  class core_scoreboard;
    logic [31:0] regs [32];
    logic [7:0]  dmem [DMEM_SIZE];
    logic        mem_busy;
    logic [31:0] held_word;
    logic [31:0] pc;
    logic [31:0] alu_last;
    logic        stopped;
    result_t     expected_q[$];
    int errors, checked;
    int n_alu, n_load, n_store, n_jump, n_other;

    function new();
      for (int i = 0; i < 32; i++) regs[i] = '0;
      for (int i = 0; i < DMEM_SIZE; i++) dmem[i] = '0;
      mem_busy = 1'b0;
      held_word = '0;
      pc = PC_RESET;
      alu_last = '0;
      stopped = 1'b0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function logic [31:0] widen_imm(logic [15:0] imm);
      return {{16{imm[15]}}, imm};
    endfunction

    function int byte_slot(logic [31:0] addr, int i);
      return int'((addr + 32'(i)) & 32'(DMEM_SIZE - 1));
    endfunction

    function logic [31:0] read_word(logic [31:0] addr);
      logic [31:0] w;
      w = '0;
      for (int i = 0; i < 4; i++) w = {w[23:0], dmem[byte_slot(addr, i)]};
      return w;
    endfunction

    function void write_word(logic [31:0] addr, logic [31:0] w);
      for (int i = 0; i < 4; i++) dmem[byte_slot(addr, i)] = w[31 - 8 * i -: 8];
    endfunction

    function void note_request(logic [31:0] word);
      result_t r;
      logic [31:0] ea, a, b;
      logic [5:0] op;
      r = '0;
      op = word[31:26];
      if (stopped) begin
        r.halted = 1'b1;
        expected_q.push_back(r);
        return;
      end
      // retire the previous load/store first
      if (mem_busy) begin
        ea = regs[held_word[25:21]] + widen_imm(held_word[15:0]);
        if (held_word[31:26] == OP_LOAD) begin
          regs[held_word[20:16]] = read_word(ea);
        end else begin
          r.store_valid = 1'b1;
          r.store_address = ea;
          r.store_value = regs[held_word[20:16]];
          write_word(ea, r.store_value);
        end
        mem_busy = 1'b0;
      end
      if (op == OP_HALT) begin
        stopped = 1'b1;
        r.halted = 1'b1;
        expected_q.push_back(r);
        return;
      end
      a = regs[word[25:21]];
      b = regs[word[20:16]];
      case (op)
        OP_RTYPE: begin
          case (word[2:0])
            FN_ADDU: alu_last = a + b;
            FN_SUBU: alu_last = a - b;
            FN_AND:  alu_last = a & b;
            FN_OR:   alu_last = a | b;
            FN_NOR:  alu_last = ~(a | b);
            default: ;
          endcase
          regs[word[15:11]] = alu_last;
          r.reg_write_valid = 1'b1;
          r.reg_write_index = word[15:11];
          r.reg_write_value = alu_last;
          n_alu++;
        end
        OP_ADDIU: begin
          alu_last = a + widen_imm(word[15:0]);
          regs[word[20:16]] = alu_last;
          r.reg_write_valid = 1'b1;
          r.reg_write_index = word[20:16];
          r.reg_write_value = alu_last;
          n_alu++;
        end
        OP_LOAD, OP_STORE: begin
          mem_busy = 1'b1;
          held_word = word;
          if (op == OP_LOAD) n_load++;
          else n_store++;
        end
        OP_JUMP: n_jump++;
        default: n_other++;
      endcase
      if (op == OP_JUMP) begin
        r.fetch_address = {6'b0, word[25:0]};
        pc = r.fetch_address + 32'd4;
      end else begin
        r.fetch_address = pc;
        pc = pc + 32'd4;
      end
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, fetch_address %h", $time,
                 got.fetch_address);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("fetch_address", want.fetch_address, got.fetch_address);
      compare_field("reg_write_valid", want.reg_write_valid, got.reg_write_valid);
      compare_field("reg_write_index", want.reg_write_index, got.reg_write_index);
      compare_field("reg_write_value", want.reg_write_value, got.reg_write_value);
      compare_field("store_valid", want.store_valid, got.store_valid);
      compare_field("store_address", want.store_address, got.store_address);
      compare_field("store_value", want.store_value, got.store_value);
      compare_field("halted", want.halted, got.halted);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        instr_valid;
  logic        instr_ready;
  logic [31:0] instruction;
  logic        result_valid;
  logic        result_ready;
  logic [31:0] fetch_address;
  logic        reg_write_valid;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        store_valid;
  logic [31:0] store_address;
  logic [31:0] store_value;
  logic        halted;

  result_t        seen;
  core_scoreboard sb;
  int             items_sent;
  int             burst_left;
  int             cycle_count;
  int             stall_mode, stall_left, stall_phase;

  mips_subset_core_step_top #(.DMEM_BYTES(DMEM_SIZE)) DUT (
    .clk(clk),
    .rst(rst),
    .instr_valid(instr_valid),
    .instr_ready(instr_ready),
    .instruction(instruction),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .fetch_address(fetch_address),
    .reg_write_valid(reg_write_valid),
    .reg_write_index(reg_write_index),
    .reg_write_value(reg_write_value),
    .store_valid(store_valid),
    .store_address(store_address),
    .store_value(store_value),
    .halted(halted)
  );

  assign seen = {fetch_address, reg_write_valid, reg_write_index, reg_write_value,
                 store_valid, store_address, store_value, halted};

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.outstanding());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && instr_valid && instr_ready) sb.note_request(instruction);
    if (!rst && result_valid && result_ready) sb.check_result(seen);
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
      stall_phase = 0;
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: result_ready = 1'b1;
      1: result_ready = ($urandom_range(0, 3) != 0);
      2: result_ready = 1'($urandom_range(0, 1));
      default: result_ready = (stall_phase % 13 == 0);
    endcase
  end

  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [2:0] fn);
    return {OP_RTYPE, rs, rt, rd, 5'($urandom), 3'($urandom), fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: w[31:26] = OP_RTYPE;
      3, 4:    w[31:26] = OP_ADDIU;
      5:       w[31:26] = OP_LOAD;
      6:       w[31:26] = OP_STORE;
      7:       w[31:26] = OP_JUMP;
      default: ;
    endcase
    while (w[31:26] == OP_HALT) w[31:26] = 6'($urandom);
    return w;
  endfunction

  task automatic send_item(input logic [31:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        instr_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    instr_valid = 1'b1;
    instruction = word;
    do @(posedge clk); while (!instr_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    instr_valid = 1'b0;
    burst_left = 0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // zero a base register, point it somewhere, then loads/stores around it
  task automatic mem_sequence();
    logic [4:0]  base, src, data_r;
    logic [15:0] origin, offs;
    int n;
    base = 5'($urandom);
    src = 5'($urandom);
    case ($urandom_range(0, 3))
      0: origin = 16'($urandom_range(0, 63));
      1: origin = 16'hFFF8 + 16'($urandom_range(0, 7));
      2: origin = 16'h8000 + 16'($urandom_range(0, 63));
      default: origin = 16'h7FC0 + 16'($urandom_range(0, 63));
    endcase
    send_item(r_word(src, src, base, FN_SUBU));
    send_item(i_word(OP_ADDIU, base, base, origin));
    n = $urandom_range(2, 8);
    repeat (n) begin
      data_r = 5'($urandom);
      offs = 16'($urandom_range(0, 16)) - 16'd8;
      case ($urandom_range(0, 5))
        0, 1: send_item(i_word(OP_STORE, base, data_r, offs));
        2, 3: send_item(i_word(OP_LOAD, base, data_r, offs));
        4: send_item(rand_word());
        default: begin
          send_item(i_word(OP_LOAD, base, data_r, offs));
          send_item(r_word(data_r, 5'($urandom), 5'($urandom), 3'($urandom)));
        end
      endcase
    end
  endtask

  initial begin
    bit drained_mid;
    clk = 1'b0;
    rst = 1'b1;
    instr_valid = 1'b0;
    instruction = '0;
    result_ready = 1'b0;
    items_sent = 0;
    burst_left = 0;
    cycle_count = 0;
    stall_mode = 0;
    stall_left = 0;
    stall_phase = 0;
    drained_mid = 1'b0;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(i_word(OP_ADDIU, 5'd0, 5'd1, 16'h7FFF));
    send_item(i_word(OP_ADDIU, 5'd0, 5'd2, 16'h8000));
    send_item(r_word(5'd1, 5'd2, 5'd3, FN_ADDU));
    send_item(r_word(5'd1, 5'd2, 5'd4, FN_SUBU));
    send_item(r_word(5'd1, 5'd2, 5'd5, FN_AND));
    send_item(r_word(5'd1, 5'd2, 5'd6, FN_OR));
    send_item(r_word(5'd0, 5'd0, 5'd7, FN_NOR));
    send_item(r_word(5'd1, 5'd2, 5'd8, 3'd0));
    send_item(r_word(5'd3, 5'd4, 5'd8, 3'd2));
    send_item(r_word(5'd5, 5'd6, 5'd8, 3'd6));
    send_item(r_word(5'd7, 5'd7, 5'd0, FN_ADDU));            // r0 = 0xFFFFFFFE
    send_item(i_word(OP_STORE, 5'd0, 5'd7, 16'h0000));       // wraps past top
    send_item(i_word(OP_LOAD, 5'd0, 5'd9, 16'h0000));
    send_item(r_word(5'd9, 5'd9, 5'd10, FN_ADDU));           // uses load result
    send_item(i_word(OP_STORE, 5'd1, 5'd10, 16'hFFFF));
    send_item(i_word(OP_STORE, 5'd1, 5'd1, 16'h7FFF));
    send_item(i_word(OP_LOAD, 5'd1, 5'd11, 16'hFFFF));
    send_item(i_word(OP_LOAD, 5'd11, 5'd12, 16'h0000));      // base from prior load
    send_item({OP_JUMP, 26'h3FFFFFF});
    send_item({OP_JUMP, 26'h0000000});
    send_item({6'd4, 26'($urandom)});
    send_item(32'hFBFF_FFFF);
    send_item(32'h0000_0000);
    send_item(i_word(OP_ADDIU, 5'd31, 5'd31, 16'hFFFF));
    wait_drained();

    while (items_sent < TOTAL_ITEMS - 2) begin
      if ($urandom_range(0, 9) < 7) mem_sequence();
      else send_item(rand_word());
      if (!drained_mid && items_sent > TOTAL_ITEMS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
    end

    send_item(i_word(OP_STORE, 5'($urandom), 5'($urandom), 16'($urandom)));
    send_item({OP_HALT, 26'($urandom)});
    wait_drained();
    repeat (40) @(negedge clk);

    $display("%0d instructions (%0d alu, %0d loads, %0d stores, %0d jumps, %0d no-ops)",
             items_sent, sb.n_alu, sb.n_load, sb.n_store, sb.n_jump, sb.n_other);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
